// ===== hw/rtl/ipv4_l4_checksum_engine_top_macros.svh =====
// Assertion macros for the IPv4/L4 checksum engine.
`ifndef IPV4_L4_CHECKSUM_ENGINE_TOP_MACROS_SVH
`define IPV4_L4_CHECKSUM_ENGINE_TOP_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled in reset.
`define CHK_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled in reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define CHK_IMPLIES(label, clk, rst_n, ante, cons)
`define CHK_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ===== hw/rtl/ipv4l4_pkg.sv =====
// Shared types, constants and helper functions of the IPv4/L4 checksum engine.
package ipv4l4_pkg;

	localparam int MAX_DATAGRAM_BYTES = 65535;
	localparam int MID_DEPTH = 4;
	localparam int OUT_DEPTH = 4;

	localparam logic [3:0] IPV4_VERSION = 4'd4;
	localparam logic [3:0] MIN_IHL = 4'd5;

	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// word indexes inside the IPv4 header
	localparam logic [15:0] IDX_VER_IHL = 16'd0;
	localparam logic [15:0] IDX_TOTAL_LEN = 16'd1;
	localparam logic [15:0] IDX_PROTO = 16'd4;
	localparam logic [15:0] IDX_HDR_CSUM = 16'd5;
	localparam logic [15:0] IDX_ADDR_FIRST = 16'd6;
	localparam logic [15:0] IDX_ADDR_LAST = 16'd9;
	localparam logic [15:0] MIN_HDR_WORDS = 16'd10;
	localparam logic [15:0] POS_SAT = 16'h8000;

	// checksum word offsets inside the L4 header
	localparam logic [15:0] ICMP_CSUM_OFF = 16'd1;
	localparam logic [15:0] UDP_CSUM_OFF = 16'd3;
	localparam logic [15:0] TCP_CSUM_OFF = 16'd8;

	localparam logic [16:0] MIN_BYTES = 17'd4;
	localparam logic [16:0] PROTO_BYTES = 17'd10;

	typedef enum logic [1:0] {
		CLASS_ICMP  = 2'd0,
		CLASS_UDP   = 2'd1,
		CLASS_TCP   = 2'd2,
		CLASS_OTHER = 2'd3
	} class_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_TRUNCATED = 2'd1,
		STATUS_MALFORMED = 2'd2
	} status_t;

	// classified word handed from front to back
	typedef struct packed {
		logic [15:0] word;
		logic        add_hdr;
		logic        add_addr;
		logic        add_pay;
		logic        last;
		status_t     status;
		class_t      cls;
		logic [15:0] pseudo;
	} word_op_t;

	typedef struct packed {
		logic [15:0] ip_hdr_csum;
		logic [15:0] payload_checksum;
		class_t      cls;
		status_t     status;
	} result_t;

	function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[15:0] + {15'b0, s[16]};
	endfunction

	function automatic class_t class_of(input logic [7:0] proto);
		class_t c;
		case (proto)
			PROTO_ICMP: c = CLASS_ICMP;
			PROTO_UDP:  c = CLASS_UDP;
			PROTO_TCP:  c = CLASS_TCP;
			default:    c = CLASS_OTHER;
		endcase
		return c;
	endfunction

endpackage

// ===== hw/rtl/ipv4l4_fifo.sv =====
// Small register-based FIFO used between engine stages.
module ipv4l4_fifo #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] store_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = store_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			store_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/ipv4l4_front.sv =====
// Front end: tracks word position, captures header fields, classifies each word.
module ipv4l4_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  accept,
	input  logic [15:0]           packet_word,
	input  logic                  odd_tail,
	input  logic                  last,
	output ipv4l4_pkg::word_op_t  op
);

	logic [15:0] pos_q;
	logic [3:0]  hw_q;
	logic [15:0] len_q;
	logic [7:0]  proto_q;
	logic        vbad_q;

	logic                  odd;
	logic [15:0]           w;
	logic [3:0]            hw_cur;
	logic                  vbad_cur;
	logic [15:0]           len_cur;
	logic [7:0]            proto_cur;
	logic [15:0]           hdr_end;
	logic [15:0]           tw;
	logic [16:0]           len_p1;
	logic [15:0]           off;
	logic                  is_hdr;
	logic                  in_pay;
	logic                  skip;
	ipv4l4_pkg::class_t    cls_q;
	logic [16:0]           bytes;
	logic [16:0]           min_len;
	ipv4l4_pkg::status_t   st;
	ipv4l4_pkg::class_t    cls_out;
	logic [15:0]           l4_len;

	always_comb begin
		odd       = last && odd_tail;
		w         = odd ? {packet_word[15:8], 8'h00} : packet_word;
		hw_cur    = (pos_q == ipv4l4_pkg::IDX_VER_IHL) ? w[11:8] : hw_q;
		vbad_cur  = (pos_q == ipv4l4_pkg::IDX_VER_IHL) ?
			(w[15:12] != ipv4l4_pkg::IPV4_VERSION) : vbad_q;
		len_cur   = (pos_q == ipv4l4_pkg::IDX_TOTAL_LEN) ? w : len_q;
		proto_cur = (pos_q == ipv4l4_pkg::IDX_PROTO) ? w[7:0] : proto_q;

		// past the fixed header all captured fields are settled; a short IHL
		// always ends malformed, so the sums it steers do not matter
		hdr_end = {11'b0, hw_q, 1'b0};
		len_p1  = {1'b0, len_q} + 17'd1;
		tw      = len_p1[16:1];
		is_hdr  = (pos_q < ipv4l4_pkg::MIN_HDR_WORDS) || (pos_q < hdr_end);
		in_pay  = !is_hdr && (pos_q < tw);
		off     = pos_q - hdr_end;
		cls_q   = ipv4l4_pkg::class_of(proto_q);
		case (cls_q)
			ipv4l4_pkg::CLASS_ICMP: skip = (off == ipv4l4_pkg::ICMP_CSUM_OFF);
			ipv4l4_pkg::CLASS_UDP:  skip = (off == ipv4l4_pkg::UDP_CSUM_OFF);
			ipv4l4_pkg::CLASS_TCP:  skip = (off == ipv4l4_pkg::TCP_CSUM_OFF);
			default:                skip = 1'b1;
		endcase

		// end-of-datagram checks
		bytes   = {pos_q, 1'b0} + (odd ? 17'd1 : 17'd2);
		min_len = {11'b0, hw_cur, 2'b00};
		if (vbad_cur || (hw_cur < ipv4l4_pkg::MIN_IHL)) begin
			st = ipv4l4_pkg::STATUS_MALFORMED;
		end else if (bytes < ipv4l4_pkg::MIN_BYTES) begin
			st = ipv4l4_pkg::STATUS_TRUNCATED;
		end else if (({1'b0, len_cur} < min_len) ||
			({1'b0, len_cur} > 17'(ipv4l4_pkg::MAX_DATAGRAM_BYTES))) begin
			st = ipv4l4_pkg::STATUS_MALFORMED;
		end else if (bytes < {1'b0, len_cur}) begin
			st = ipv4l4_pkg::STATUS_TRUNCATED;
		end else begin
			st = ipv4l4_pkg::STATUS_OK;
		end

		if (st == ipv4l4_pkg::STATUS_MALFORMED) begin
			cls_out = ipv4l4_pkg::CLASS_OTHER;
		end else if (st == ipv4l4_pkg::STATUS_TRUNCATED && bytes < ipv4l4_pkg::PROTO_BYTES) begin
			cls_out = ipv4l4_pkg::CLASS_OTHER;
		end else begin
			cls_out = ipv4l4_pkg::class_of(proto_cur);
		end

		l4_len = len_cur - min_len[15:0];

		op.word = w;
		// odd total length: last payload word keeps only its high byte
		if (in_pay && len_q[0] && (pos_q == tw - 16'd1)) begin
			op.word = {w[15:8], 8'h00};
		end
		op.add_hdr  = is_hdr && (pos_q != ipv4l4_pkg::IDX_HDR_CSUM);
		op.add_addr = is_hdr && (pos_q >= ipv4l4_pkg::IDX_ADDR_FIRST) &&
			(pos_q <= ipv4l4_pkg::IDX_ADDR_LAST);
		op.add_pay  = in_pay && !skip;
		op.last     = last;
		op.status   = st;
		op.cls      = cls_out;
		op.pseudo   = ipv4l4_pkg::ones_add({8'h00, proto_cur}, l4_len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			hw_q    <= '0;
			len_q   <= '0;
			proto_q <= '0;
			vbad_q  <= 1'b0;
		end else if (accept) begin
			if (last) begin
				pos_q   <= '0;
				hw_q    <= '0;
				len_q   <= '0;
				proto_q <= '0;
				vbad_q  <= 1'b0;
			end else begin
				if (pos_q != ipv4l4_pkg::POS_SAT) begin
					pos_q <= pos_q + 16'd1;
				end
				if (pos_q == ipv4l4_pkg::IDX_VER_IHL) begin
					hw_q   <= hw_cur;
					vbad_q <= vbad_cur;
				end
				if (pos_q == ipv4l4_pkg::IDX_TOTAL_LEN) begin
					len_q <= len_cur;
				end
				if (pos_q == ipv4l4_pkg::IDX_PROTO) begin
					proto_q <= proto_cur;
				end
			end
		end
	end

endmodule

// ===== hw/rtl/ipv4l4_back.sv =====
// Back end: one's-complement accumulators and a two-stage checksum finish.
module ipv4l4_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  op_avail,
	input  ipv4l4_pkg::word_op_t  op,
	output logic                  op_take,
	input  logic                  res_full,
	output logic                  res_valid,
	output ipv4l4_pkg::result_t   res
);

	logic [15:0] hs_q, ps_q, as_q;
	logic [15:0] hs_n, ps_n, as_n;
	logic        en;

	logic                 v_s1;
	logic [15:0]          hs_s1, ps_s1, as_s1, pseudo_s1;
	ipv4l4_pkg::class_t   cls_s1;
	ipv4l4_pkg::status_t  st_s1;

	logic                 v_s2;
	logic [15:0]          hc_s2, ps_s2, sum_s2, pseudo_s2;
	ipv4l4_pkg::class_t   cls_s2;
	ipv4l4_pkg::status_t  st_s2;

	logic [15:0] pc;

	// whole back end holds while the result queue is full
	assign en      = !res_full;
	assign op_take = op_avail && en;

	always_comb begin
		hs_n = op.add_hdr  ? ipv4l4_pkg::ones_add(hs_q, op.word) : hs_q;
		as_n = op.add_addr ? ipv4l4_pkg::ones_add(as_q, op.word) : as_q;
		ps_n = op.add_pay  ? ipv4l4_pkg::ones_add(ps_q, op.word) : ps_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hs_q <= '0;
			ps_q <= '0;
			as_q <= '0;
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			if (op_take) begin
				if (op.last) begin
					hs_q <= '0;
					ps_q <= '0;
					as_q <= '0;
				end else begin
					hs_q <= hs_n;
					ps_q <= ps_n;
					as_q <= as_n;
				end
			end
			v_s1 <= op_take && op.last;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hs_s1     <= hs_n;
			ps_s1     <= ps_n;
			as_s1     <= as_n;
			pseudo_s1 <= op.pseudo;
			cls_s1    <= op.cls;
			st_s1     <= op.status;

			hc_s2     <= (st_s1 == ipv4l4_pkg::STATUS_OK) ? ~hs_s1 : 16'h0000;
			ps_s2     <= ps_s1;
			sum_s2    <= ipv4l4_pkg::ones_add(ps_s1, as_s1);
			pseudo_s2 <= pseudo_s1;
			cls_s2    <= cls_s1;
			st_s2     <= st_s1;
		end
	end

	always_comb begin
		pc = 16'h0000;
		if (st_s2 == ipv4l4_pkg::STATUS_OK) begin
			case (cls_s2)
				ipv4l4_pkg::CLASS_ICMP: pc = ~ps_s2;
				ipv4l4_pkg::CLASS_UDP,
				ipv4l4_pkg::CLASS_TCP:  pc = ~ipv4l4_pkg::ones_add(sum_s2, pseudo_s2);
				default:                pc = 16'h0000;
			endcase
		end
		res.ip_hdr_csum      = hc_s2;
		res.payload_checksum = pc;
		res.cls              = cls_s2;
		res.status           = st_s2;
	end

	assign res_valid = v_s2 && en;

endmodule

// ===== hw/rtl/ipv4_l4_checksum_engine_top.sv =====
// IPv4 header and ICMP/UDP/TCP checksum engine, one 16-bit word per beat.
// Throughput: one word beat per cycle, sustained, both sides unstalled.
// Path: a datagram's result passes the word queue, the two finish stages and the result queue
// before it shows on the outputs; a full result queue holds the whole back end.
// Reset: arst_n clears positions, sums and both queues; results pending are dropped.
`include "ipv4_l4_checksum_engine_top_macros.svh"

module ipv4_l4_checksum_engine_top #(
	parameter int MID_DEPTH = ipv4l4_pkg::MID_DEPTH,
	parameter int OUT_DEPTH = ipv4l4_pkg::OUT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [15:0] packet_word,
	input  logic        odd_tail,
	input  logic        last,
	output logic        empty,
	input  logic        pop,
	output logic [15:0] ip_hdr_csum,
	output logic [15:0] payload_checksum,
	output logic [1:0]  protocol_class,
	output logic [1:0]  status
);

	localparam int OP_W  = $bits(ipv4l4_pkg::word_op_t);
	localparam int RES_W = $bits(ipv4l4_pkg::result_t);

	logic                 in_beat;
	ipv4l4_pkg::word_op_t op_in, op_head;
	logic                 mid_empty, op_take;
	logic                 res_full, res_valid;
	ipv4l4_pkg::result_t  res_in, res_head;

	assign in_beat = push && !full;

	ipv4l4_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (in_beat),
		.packet_word (packet_word),
		.odd_tail    (odd_tail),
		.last        (last),
		.op          (op_in)
	);

	ipv4l4_fifo #(
		.WIDTH (OP_W),
		.DEPTH (MID_DEPTH)
	) u_midq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (in_beat),
		.wr_data (op_in),
		.rd_en   (op_take),
		.rd_data (op_head),
		.full    (full),
		.empty   (mid_empty)
	);

	ipv4l4_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_avail  (!mid_empty),
		.op        (op_head),
		.op_take   (op_take),
		.res_full  (res_full),
		.res_valid (res_valid),
		.res       (res_in)
	);

	ipv4l4_fifo #(
		.WIDTH (RES_W),
		.DEPTH (OUT_DEPTH)
	) u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (res_valid),
		.wr_data (res_in),
		.rd_en   (pop),
		.rd_data (res_head),
		.full    (res_full),
		.empty   (empty)
	);

	assign ip_hdr_csum      = res_head.ip_hdr_csum;
	assign payload_checksum = res_head.payload_checksum;
	assign protocol_class   = res_head.cls;
	assign status           = res_head.status;

	// a finished result is never offered to a full result queue
	`CHK_IMPLIES(a_res_room, clk, arst_n, res_valid, !res_full)
	// error results carry no checksums
	`CHK_IMPLIES(a_err_zero, clk, arst_n, !empty && (status != ipv4l4_pkg::STATUS_OK),
		(ip_hdr_csum == 16'h0000) && (payload_checksum == 16'h0000))
	// malformed datagrams report no protocol
	`CHK_IMPLIES(a_mal_cls, clk, arst_n, !empty && (status == ipv4l4_pkg::STATUS_MALFORMED),
		protocol_class == ipv4l4_pkg::CLASS_OTHER)
	// back end takes a word whenever one waits and results have room
	`CHK_NEXT(a_mid_drain, clk, arst_n, !mid_empty && !res_full && !in_beat,
		$past(op_take))

endmodule

// ===== verif/tb_ipv4_l4_checksum_engine_top.sv =====
// Self-checking testbench for the IPv4 header and ICMP/UDP/TCP checksum engine.
module tb_ipv4_l4_checksum_engine_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 8;
	localparam int HOLD_OFF_CYCLES = 500;
	localparam int LONG_STREAM_WORDS = 256;

	typedef struct packed {
		logic [15:0]         hdr_csum;
		logic [15:0]         pay_csum;
		ipv4l4_pkg::class_t  cls;
		ipv4l4_pkg::status_t st;
	} csum_result_t;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [15:0] packet_word;
	logic        odd_tail;
	logic        last;
	logic        empty;
	logic        pop;
	logic [15:0] ip_hdr_csum;
	logic [15:0] payload_checksum;
	logic [1:0]  protocol_class;
	logic [1:0]  status;

	ipv4_l4_checksum_engine_top dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.push             (push),
		.full             (full),
		.packet_word      (packet_word),
		.odd_tail         (odd_tail),
		.last             (last),
		.empty            (empty),
		.pop              (pop),
		.ip_hdr_csum      (ip_hdr_csum),
		.payload_checksum (payload_checksum),
		.protocol_class   (protocol_class),
		.status           (status)
	);

	// datagram tracking state of the predictor
	logic [14:0] pos;
	bit          pos_sat;
	logic [3:0]  ihl;
	logic [15:0] dlen;
	logic [7:0]  proto;
	logic [15:0] sum_hdr;
	logic [15:0] sum_pay;
	logic [15:0] sum_addr;
	bit          ver_bad;

	csum_result_t expected_results[$];
	logic [15:0]  dg_words[$];
	bit           dg_odd_end;

	int send_idle_pct = 0;
	int pop_idle_pct = 0;
	int hold_req = 0;
	int hold_done = 0;
	int hold_cycles = 0;
	int words_sent = 0;
	int results_seen = 0;
	int errors = 0;
	int stall_count = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [15:0] fold_add(input logic [15:0] a, input logic [15:0] b);
		int s;
		s = int'(a) + int'(b);
		return 16'(s + (s >> 16));
	endfunction

	function automatic ipv4l4_pkg::class_t proto_class(input logic [7:0] p);
		ipv4l4_pkg::class_t c;
		case (p)
			ipv4l4_pkg::PROTO_ICMP: c = ipv4l4_pkg::CLASS_ICMP;
			ipv4l4_pkg::PROTO_UDP:  c = ipv4l4_pkg::CLASS_UDP;
			ipv4l4_pkg::PROTO_TCP:  c = ipv4l4_pkg::CLASS_TCP;
			default:                c = ipv4l4_pkg::CLASS_OTHER;
		endcase
		return c;
	endfunction

	function automatic void clear_datagram_state();
		pos = '0;
		pos_sat = 1'b0;
		ihl = '0;
		dlen = '0;
		proto = '0;
		sum_hdr = '0;
		sum_pay = '0;
		sum_addr = '0;
		ver_bad = 1'b0;
	endfunction

	// Advances the datagram state by one word; returns 1 when the word closes a datagram.
	function automatic bit predict_checksum_word(input logic [15:0] word_in, input bit odd_in,
			input bit last_in, output csum_result_t res);
		logic [15:0]         w;
		logic [15:0]         s;
		bit                  odd;
		bit                  skip;
		int                  idx;
		int                  hdr_end;
		int                  tw;
		int                  off;
		int                  nbytes;
		ipv4l4_pkg::class_t  c;
		ipv4l4_pkg::status_t st;
		res = '0;
		odd = last_in && odd_in;
		w = word_in;
		idx = pos_sat ? int'(ipv4l4_pkg::POS_SAT) : int'(pos);
		if (odd)
			w = w & 16'hFF00;
		if (idx == int'(ipv4l4_pkg::IDX_VER_IHL)) begin
			ver_bad = (w[15:12] != ipv4l4_pkg::IPV4_VERSION);
			ihl = w[11:8];
		end else if (idx == int'(ipv4l4_pkg::IDX_TOTAL_LEN)) begin
			dlen = w;
		end else if (idx == int'(ipv4l4_pkg::IDX_PROTO)) begin
			proto = w[7:0];
		end
		hdr_end = int'(ihl) * 2;
		tw = (int'(dlen) + 1) >> 1;
		c = proto_class(proto);
		if (idx < hdr_end) begin
			if (idx != int'(ipv4l4_pkg::IDX_HDR_CSUM))
				sum_hdr = fold_add(sum_hdr, w);
			if (idx >= int'(ipv4l4_pkg::IDX_ADDR_FIRST) &&
				idx <= int'(ipv4l4_pkg::IDX_ADDR_LAST))
				sum_addr = fold_add(sum_addr, w);
		end else if (idx < tw) begin
			off = idx - hdr_end;
			skip = (c == ipv4l4_pkg::CLASS_ICMP && off == int'(ipv4l4_pkg::ICMP_CSUM_OFF)) ||
				(c == ipv4l4_pkg::CLASS_UDP && off == int'(ipv4l4_pkg::UDP_CSUM_OFF)) ||
				(c == ipv4l4_pkg::CLASS_TCP && off == int'(ipv4l4_pkg::TCP_CSUM_OFF)) ||
				c == ipv4l4_pkg::CLASS_OTHER;
			// odd total length: final byte zero padded
			if (dlen[0] && idx == tw - 1)
				w = w & 16'hFF00;
			if (!skip)
				sum_pay = fold_add(sum_pay, w);
		end
		if (!pos_sat) begin
			if (pos == 15'h7FFF)
				pos_sat = 1'b1;
			else
				pos = pos + 15'd1;
		end
		if (!last_in)
			return 1'b0;

		nbytes = idx * 2 + (odd ? 1 : 2);
		if (ver_bad || ihl < ipv4l4_pkg::MIN_IHL)
			st = ipv4l4_pkg::STATUS_MALFORMED;
		else if (nbytes < int'(ipv4l4_pkg::MIN_BYTES))
			st = ipv4l4_pkg::STATUS_TRUNCATED;
		else if (int'(dlen) < int'(ihl) * 4 || int'(dlen) > ipv4l4_pkg::MAX_DATAGRAM_BYTES)
			st = ipv4l4_pkg::STATUS_MALFORMED;
		else if (nbytes < int'(dlen))
			st = ipv4l4_pkg::STATUS_TRUNCATED;
		else
			st = ipv4l4_pkg::STATUS_OK;

		if (st == ipv4l4_pkg::STATUS_MALFORMED)
			c = ipv4l4_pkg::CLASS_OTHER;
		else if (st == ipv4l4_pkg::STATUS_TRUNCATED && nbytes < int'(ipv4l4_pkg::PROTO_BYTES))
			c = ipv4l4_pkg::CLASS_OTHER;

		if (st == ipv4l4_pkg::STATUS_OK) begin
			res.hdr_csum = ~sum_hdr;
			if (c == ipv4l4_pkg::CLASS_ICMP) begin
				res.pay_csum = ~sum_pay;
			end else if (c == ipv4l4_pkg::CLASS_UDP || c == ipv4l4_pkg::CLASS_TCP) begin
				s = fold_add(sum_pay, sum_addr);
				s = fold_add(s, {8'd0, proto});
				s = fold_add(s, 16'(int'(dlen) - int'(ihl) * 4));
				res.pay_csum = ~s;
			end
		end
		res.cls = c;
		res.st = st;
		clear_datagram_state();
		return 1'b1;
	endfunction

	task automatic send_word(input logic [15:0] w, input bit odd, input bit lst);
		csum_result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		packet_word <= w;
		odd_tail <= odd;
		last <= lst;
		do begin
			@(posedge clk);
		end while (full);
		words_sent++;
		if (predict_checksum_word(w, odd, lst, res))
			expected_results.push_back(res);
	endtask

	// odd_tail toggles at random on inner words, where the block ignores it
	task automatic send_datagram();
		int n;
		n = dg_words.size();
		for (int i = 0; i < n; i++)
			send_word(dg_words[i], (i == n - 1) ? dg_odd_end : 1'($urandom_range(1)), i == n - 1);
	endtask

	function automatic void build_random_datagram(input int max_payload);
		int         kind;
		int         ihl_v;
		int         dlen_v;
		int         nw;
		logic [7:0] proto_v;
		dg_words.delete();
		kind = $urandom_range(99);
		if (kind >= 94) begin
			repeat ($urandom_range(20, 1))
				dg_words.push_back(16'($urandom_range(16'hFFFF)));
			dg_odd_end = 1'($urandom_range(1));
			return;
		end
		ihl_v = ($urandom_range(3) == 0) ? $urandom_range(15, 5) : 5;
		dlen_v = ihl_v * 4 + $urandom_range(max_payload);
		case ($urandom_range(3))
			0: proto_v = ipv4l4_pkg::PROTO_ICMP;
			1: proto_v = ipv4l4_pkg::PROTO_UDP;
			2: proto_v = ipv4l4_pkg::PROTO_TCP;
			default: proto_v = 8'($urandom_range(255));
		endcase
		nw = (dlen_v + 1) / 2;
		repeat (nw)
			dg_words.push_back(16'($urandom_range(16'hFFFF)));
		dg_words[0] = {ipv4l4_pkg::IPV4_VERSION, 4'(ihl_v), 8'($urandom_range(255))};
		dg_words[1] = 16'(dlen_v);
		dg_words[4] = {8'($urandom_range(255)), proto_v};
		dg_odd_end = 1'(dlen_v % 2);
		if (kind >= 70 && kind < 80) begin
			// trailing words past the total length
			repeat ($urandom_range(3, 1))
				dg_words.push_back(16'($urandom_range(16'hFFFF)));
			dg_odd_end = 1'($urandom_range(1));
		end else if (kind >= 80 && kind < 88) begin
			repeat ($urandom_range(nw - 1, 1))
				void'(dg_words.pop_back());
			dg_odd_end = 1'($urandom_range(1));
		end else if (kind >= 88) begin
			case ($urandom_range(2))
				0: dg_words[0][15:12] = 4'($urandom_range(15));
				1: dg_words[0][11:8] = 4'($urandom_range(4));
				default: dg_words[1] = 16'($urandom_range(16'hFFFF));
			endcase
		end
	endfunction

	task automatic wait_results_drained();
		push <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_directed();
		send_idle_pct = 0;
		pop_idle_pct = 0;
		// single odd byte: too short to hold a header
		dg_words = '{16'h45FF};
		dg_odd_end = 1'b1;
		send_datagram();
		dg_words = '{16'h6500};
		dg_odd_end = 1'b0;
		send_datagram();
		// header length below minimum
		dg_words = '{16'h4400, 16'h0014};
		send_datagram();
		// total length shorter than the header
		dg_words = '{16'h4500, 16'h0010};
		send_datagram();
		// truncated right after the protocol byte
		dg_words = '{16'h4500, 16'd40, 16'h0000, 16'h0000, 16'h4011};
		send_datagram();
		// ICMP, odd payload byte, then one word past the total length
		dg_words = '{16'h4500, 16'd21, 16'h1C46, 16'h4000, 16'hFF01, 16'hB1E6, 16'hC0A8,
			16'h0001, 16'hC0A8, 16'h00C7, 16'hABCD, 16'h1234};
		send_datagram();
		// UDP with every other field saturated
		dg_words = '{16'h45FF, 16'd28, 16'hFFFF, 16'hFFFF, 16'hFF11, 16'hFFFF, 16'hFFFF,
			16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		send_datagram();
	endtask

	// maximum total length on a long stream that still ends short of it
	task automatic test_long_stream();
		send_idle_pct = 0;
		pop_idle_pct = 0;
		dg_words.delete();
		repeat (LONG_STREAM_WORDS)
			dg_words.push_back(16'($urandom_range(16'hFFFF)));
		dg_words[0] = {ipv4l4_pkg::IPV4_VERSION, ipv4l4_pkg::MIN_IHL, 8'($urandom_range(255))};
		dg_words[1] = 16'hFFFF;
		dg_words[4] = {8'($urandom_range(255)), ipv4l4_pkg::PROTO_UDP};
		dg_odd_end = 1'($urandom_range(1));
		send_datagram();
	endtask

	task automatic test_random_traffic(input int send_pct, input int pop_pct, input int n_words);
		int target;
		send_idle_pct = send_pct;
		pop_idle_pct = pop_pct;
		target = words_sent + n_words;
		while (words_sent < target) begin
			build_random_datagram(($urandom_range(15) == 0) ? 600 : 40);
			send_datagram();
		end
	endtask

	// receiver holds off while short datagrams keep coming, so the block backs up
	task automatic test_backpressure();
		send_idle_pct = 0;
		pop_idle_pct = 0;
		hold_req++;
		repeat (20) begin
			build_random_datagram(8);
			send_datagram();
		end
	endtask

	always @(posedge clk) begin
		if (hold_cycles == 0 && hold_done != hold_req) begin
			hold_done = hold_req;
			hold_cycles = HOLD_OFF_CYCLES;
		end
		if (hold_cycles > 0) begin
			pop <= 1'b0;
			hold_cycles--;
		end else begin
			pop <= ($urandom_range(99) >= pop_idle_pct);
		end
	end

	always @(posedge clk) begin
		csum_result_t exp_r;
		if (arst_n && pop && !empty) begin
			results_seen++;
			if (expected_results.size() == 0) begin
				$error("result beat with no datagram pending");
				errors++;
			end else begin
				exp_r = expected_results.pop_front();
				if (ip_hdr_csum !== exp_r.hdr_csum) begin
					$error("ip_hdr_csum: expected %h, got %h", exp_r.hdr_csum, ip_hdr_csum);
					errors++;
				end
				if (payload_checksum !== exp_r.pay_csum) begin
					$error("payload_checksum: expected %h, got %h", exp_r.pay_csum,
						payload_checksum);
					errors++;
				end
				if (protocol_class !== exp_r.cls) begin
					$error("protocol_class: expected %0d, got %0d", exp_r.cls, protocol_class);
					errors++;
				end
				if (status !== exp_r.st) begin
					$error("status: expected %0d, got %0d", exp_r.st, status);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (push && !full) || (pop && !empty)) begin
			stall_count = 0;
		end else begin
			stall_count++;
			if (stall_count >= STALL_LIMIT) begin
				$display("ipv4_l4_checksum_engine_top: mismatch");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		push <= 1'b0;
		packet_word <= '0;
		odd_tail <= 1'b0;
		last <= 1'b0;
		clear_datagram_state();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		wait_results_drained();
		test_long_stream();
		wait_results_drained();
		test_random_traffic(10, 74, 400);
		wait_results_drained();
		test_random_traffic(74, 10, 400);
		test_backpressure();
		wait_results_drained();
		test_random_traffic(0, 0, 400);
		wait_results_drained();

		$display("covered: %0d word beats, %0d results checked", words_sent, results_seen);
		$display("  header faults, truncation, odd tails, trailing words, long stream, stalls");
		if (errors == 0)
			$display("ipv4_l4_checksum_engine_top: match");
		else
			$display("ipv4_l4_checksum_engine_top: mismatch");
		$finish;
	end

endmodule
